>>> rtl/core/b2da_pkg.sv
// Shared types and constants for the binary to decimal ASCII converter.
package b2da_pkg;

	localparam int VALUE_W        = 32;
	localparam int DIGIT_W        = 4;
	localparam int CHAR_W         = 6;
	localparam int PAD_W          = 5;
	localparam int MAX_DIGITS_DEF = 10;

	localparam logic [PAD_W-1:0]  MAX_WIDTH  = 5'd16;
	localparam logic [CHAR_W-1:0] CHAR_SPACE = 6'd32;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;

	// Operation applied to every digit cell at once
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_CLEAR,
		CELL_DABBLE,
		CELL_SHIFT
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
	} cell_ctrl_t;

endpackage

>>> rtl/core/b2da_if.sv
// Handshake channel interfaces: number in, characters out, pad width write.
interface b2da_value_if import b2da_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] value;
	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface b2da_char_if import b2da_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] character;
	logic              last;
	modport source (output valid, output character, output last, input ready);
	modport sink   (input valid, input character, input last, output ready);
endinterface

interface b2da_cfg_if import b2da_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PAD_W-1:0] pad_width;
	modport source (output valid, output pad_width, input ready);
	modport sink   (input valid, input pad_width, output ready);
endinterface

>>> rtl/core/b2da_cell.sv
// One BCD digit cell: shift-add-3 conversion step, or shift towards the top.
module b2da_cell import b2da_pkg::*; (
	input  logic               clk,
	input  cell_ctrl_t         ctrl,
	input  logic               bit_in,
	input  logic [DIGIT_W-1:0] digit_in,
	output logic               bit_out,
	output logic [DIGIT_W-1:0] digit
);

	logic [DIGIT_W-1:0] digit_q;
	logic [DIGIT_W-1:0] adj;

	// add three when the digit would reach ten after doubling
	assign adj     = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
	assign bit_out = adj[DIGIT_W-1];
	assign digit   = digit_q;

	always_ff @(posedge clk) begin
		case (ctrl.op)
			CELL_CLEAR:  digit_q <= '0;
			CELL_DABBLE: digit_q <= {adj[DIGIT_W-2:0], bit_in};
			CELL_SHIFT:  digit_q <= digit_in;
			default:     digit_q <= digit_q;
		endcase
	end

endmodule

>>> rtl/core/binary_to_decimal_ascii.sv
// Binary to decimal ASCII converter: a 32-bit number in, right-justified digits out.
//
// Channels: number (valid/ready, value) takes one unsigned 32-bit item; text
// (valid/ready, character, last) gives its characters one item at a time,
// leading spaces first, then the digits most significant first, with last set
// on the final digit; cfg (valid/ready, pad_width) sets the field width and is
// always ready. Widths above sixteen act as sixteen.
// The number goes through a row of MAX_DIGITS BCD cells, one value bit a
// cycle. Leading zeros are then shifted out of the top cell, one a cycle,
// up to MAX_DIGITS-1 of them; the strip state then sets up the spaces, and
// the pad state gives the spaces out. Each character then passes through
// the output register.
// number.ready is high only while no item is in work; the next item may be
// taken while the final character still waits in the output register.
// A stalled receiver holds the output register; spaces and cells then wait, conversion does not.
// Reset clears the control state and sets the pad width to zero.
module binary_to_decimal_ascii import b2da_pkg::*; #(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	b2da_value_if.sink  number,
	b2da_char_if.source text,
	b2da_cfg_if.sink    cfg
);

	localparam int CW   = $clog2(MAX_DIGITS + 1);
	localparam int CMPW = ((CW > PAD_W) ? CW : PAD_W) + 1;
	localparam int BCW  = $clog2(VALUE_W);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CONV  = 3'd1;
	localparam logic [2:0] ST_STRIP = 3'd2;
	localparam logic [2:0] ST_PAD   = 3'd3;
	localparam logic [2:0] ST_DIGIT = 3'd4;

	logic [2:0]         state_q;
	logic [VALUE_W-1:0] shift_q;
	logic [BCW-1:0]     bit_cnt_q;
	logic [CW-1:0]      count_q;
	logic               ovf_q;
	logic [PAD_W-1:0]   spaces_q;
	logic [PAD_W-1:0]   pad_width_q;
	logic               out_valid_q;
	logic [CHAR_W-1:0]  out_char_q;
	logic               out_last_q;

	cell_ctrl_t         cell_ctrl;
	logic [MAX_DIGITS-1:0]              carry;
	logic [MAX_DIGITS-1:0][DIGIT_W-1:0] digits;
	logic [DIGIT_W-1:0] top_digit;
	logic               can_load;
	logic               in_acc;
	logic [PAD_W-1:0]   width_sat;
	logic [CMPW-1:0]    width_ext;
	logic [CMPW-1:0]    count_ext;
	logic [CMPW-1:0]    spaces_calc;

	assign in_acc       = number.valid && number.ready;
	assign number.ready = (state_q == ST_IDLE);
	assign cfg.ready    = 1'b1;
	assign can_load     = !out_valid_q || text.ready;
	assign top_digit    = digits[MAX_DIGITS-1];

	assign text.valid     = out_valid_q;
	assign text.character = out_char_q;
	assign text.last      = out_last_q;

	// padding from the saturated width and the digit count
	assign width_sat   = (pad_width_q > MAX_WIDTH) ? MAX_WIDTH : pad_width_q;
	assign width_ext   = CMPW'(width_sat);
	assign count_ext   = CMPW'(count_q);
	assign spaces_calc = (width_ext > count_ext) ? width_ext - count_ext : '0;

	// cell row operation for this cycle
	always_comb begin
		cell_ctrl.op = CELL_HOLD;
		case (state_q)
			ST_IDLE:  if (in_acc) cell_ctrl.op = CELL_CLEAR;
			ST_CONV:  cell_ctrl.op = CELL_DABBLE;
			ST_STRIP: begin
				if (top_digit == '0 && count_q > CW'(1) && !ovf_q)
					cell_ctrl.op = CELL_SHIFT;
			end
			ST_DIGIT: if (can_load) cell_ctrl.op = CELL_SHIFT;
			default:  cell_ctrl.op = CELL_HOLD;
		endcase
	end

	// digit cells, least significant at index zero
	for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
		b2da_cell u_cell (
			.clk      (clk),
			.ctrl     (cell_ctrl),
			.bit_in   ((i == 0) ? shift_q[VALUE_W-1] : carry[(i == 0) ? 0 : i - 1]),
			.digit_in ((i == 0) ? DIGIT_W'(0) : digits[(i == 0) ? 0 : i - 1]),
			.bit_out  (carry[i]),
			.digit    (digits[i])
		);
	end

	// pad width register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_width_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			pad_width_q <= cfg.pad_width;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			bit_cnt_q <= '0;
			count_q   <= '0;
			ovf_q     <= 1'b0;
			spaces_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q   <= ST_CONV;
						bit_cnt_q <= '0;
						ovf_q     <= 1'b0;
					end
				end
				ST_CONV: begin
					// overflow out of the top cell keeps all cells as digits
					ovf_q     <= ovf_q | carry[MAX_DIGITS-1];
					bit_cnt_q <= bit_cnt_q + BCW'(1);
					if (bit_cnt_q == BCW'(VALUE_W - 1)) begin
						state_q <= ST_STRIP;
						count_q <= CW'(MAX_DIGITS);
					end
				end
				ST_STRIP: begin
					if (top_digit == '0 && count_q > CW'(1) && !ovf_q) begin
						count_q <= count_q - CW'(1);
					end else begin
						spaces_q <= spaces_calc[PAD_W-1:0];
						state_q  <= ST_PAD;
					end
				end
				ST_PAD: begin
					if (spaces_q == '0) begin
						state_q <= ST_DIGIT;
					end else if (can_load) begin
						spaces_q <= spaces_q - PAD_W'(1);
					end
				end
				ST_DIGIT: begin
					if (can_load) begin
						count_q <= count_q - CW'(1);
						if (count_q == CW'(1)) state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// value shifter, MSB first into the bottom cell
	always_ff @(posedge clk) begin
		if (in_acc) begin
			shift_q <= number.value;
		end else if (state_q == ST_CONV) begin
			shift_q <= {shift_q[VALUE_W-2:0], 1'b0};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (can_load) begin
			out_valid_q <= (state_q == ST_PAD && spaces_q != '0) || (state_q == ST_DIGIT);
		end
	end

	always_ff @(posedge clk) begin
		if (can_load) begin
			if (state_q == ST_DIGIT) begin
				out_char_q <= CHAR_ZERO + CHAR_W'(top_digit);
				out_last_q <= (count_q == CW'(1));
			end else begin
				out_char_q <= CHAR_SPACE;
				out_last_q <= 1'b0;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_CONV && bit_cnt_q == '0))
		else $error("accepted item did not start conversion");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIGIT && can_load && count_q == CW'(1)) |=> (state_q == ST_IDLE))
		else $error("final digit did not end the run");

	a_digit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIGIT) |-> (count_q != '0 && count_q <= CW'(MAX_DIGITS)))
		else $error("digit count out of range while emitting");

	a_last_is_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_last_q) |-> (out_char_q != CHAR_SPACE))
		else $error("last flag on a padding space");
`endif

endmodule

>>> verif/binary_to_decimal_ascii_tb.sv
// Testbench for the binary to decimal ASCII converter: directed and random numbers.
`timescale 1ns / 1ps

module binary_to_decimal_ascii_tb;
	import b2da_pkg::*;

	// One expected character of a number's text
	typedef struct packed {
		logic [CHAR_W-1:0] character;
		logic              last;
	} text_char_t;

	// Predicts the text of each accepted number and checks the characters as they come
	class text_scoreboard;
		text_char_t       expected_text[$];
		logic [PAD_W-1:0] field_width;
		int unsigned      errors;

		function new();
			field_width = '0;
			errors = 0;
		endfunction

		function void set_width(logic [PAD_W-1:0] w);
			field_width = w;
		endfunction

		function int pending();
			return expected_text.size();
		endfunction

		// Split into digits, work out the leading spaces, queue the characters
		function void note_number(logic [VALUE_W-1:0] v);
			logic [DIGIT_W-1:0] digits [MAX_DIGITS_DEF];
			logic [VALUE_W-1:0] rest;
			text_char_t         ch;
			int                 count;
			int                 width;
			int                 spaces;
			rest = v;
			count = 0;
			// zero still yields one digit
			do begin
				digits[count] = DIGIT_W'(rest % 10);
				count++;
				rest = rest / 10;
			end while (rest != 0 && count < MAX_DIGITS_DEF);
			width = (field_width > MAX_WIDTH) ? int'(MAX_WIDTH) : int'(field_width);
			spaces = (width > count) ? width - count : 0;
			for (int k = 0; k < spaces; k++) begin
				ch.character = CHAR_SPACE;
				ch.last = 1'b0;
				expected_text.push_back(ch);
			end
			for (int k = count; k > 0; k--) begin
				ch.character = CHAR_W'(CHAR_ZERO + digits[k-1]);
				ch.last = (k == 1);
				expected_text.push_back(ch);
			end
		endfunction

		function void report(string msg);
			errors++;
			if (errors <= 10)
				$display("%0t: mismatch: %s", $time, msg);
		endfunction

		function void check_char(logic [CHAR_W-1:0] character, logic last);
			text_char_t want;
			if (expected_text.size() == 0) begin
				report($sformatf("unexpected character %0d last %0b", character, last));
				return;
			end
			want = expected_text.pop_front();
			if (want.character !== character || want.last !== last)
				report($sformatf("character exp %0d got %0d, last exp %0b got %0b",
					want.character, character, want.last, last));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   steady;   // phase with no idling on either side

	b2da_value_if number_ch ();
	b2da_char_if  text_ch ();
	b2da_cfg_if   cfg_ch ();

	text_scoreboard ledger = new();

	binary_to_decimal_ascii uut (
		.clk    (clk),
		.arst_n (arst_n),
		.number (number_ch),
		.text   (text_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Overall time limit
	initial begin
		#5_000_000;
		$display("binary_to_decimal_ascii_tb: errors");
		$finish;
	end

	// Offer one number; valid is left high so a back-to-back item keeps it up
	task automatic send_number(input logic [VALUE_W-1:0] v);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			number_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		number_ch.valid <= 1'b1;
		number_ch.value <= v;
		do @(posedge clk); while (!number_ch.ready);
		ledger.note_number(v);
	endtask

	task automatic number_idle();
		number_ch.valid <= 1'b0;
	endtask

	// Stop offering numbers and wait for every queued character
	task automatic drain();
		number_idle();
		while (ledger.pending() > 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_width(input logic [PAD_W-1:0] w);
		drain();
		cfg_ch.valid <= 1'b1;
		cfg_ch.pad_width <= w;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		ledger.set_width(w);
	endtask

	// Mostly numbers of a random digit length, some fully random words
	function automatic logic [VALUE_W-1:0] random_number();
		int          len;
		longint      lo;
		longint      hi;
		if ($urandom_range(0, 3) == 0)
			return $urandom();
		len = $urandom_range(1, 10);
		lo = (len == 1) ? 0 : 10 ** (len - 1);
		hi = 10 ** len - 1;
		if (hi > 64'hFFFF_FFFF)
			hi = 64'hFFFF_FFFF;
		return $urandom_range(32'(hi), 32'(lo));
	endfunction

	function automatic logic [PAD_W-1:0] random_width();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return MAX_WIDTH;
			2: return '1;
			default: return PAD_W'($urandom_range(0, 31));
		endcase
	endfunction

	// Receiver: random stall before each character, then ready until one is taken
	initial begin
		int stall;
		text_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 12);
			if (stall > 0) begin
				text_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			text_ch.ready <= 1'b1;
			do @(posedge clk); while (!(text_ch.valid && text_ch.ready));
			ledger.check_char(text_ch.character, text_ch.last);
		end
	end

	// Main sequence
	initial begin
		arst_n <= 1'b0;
		number_ch.valid <= 1'b0;
		number_ch.value <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.pad_width <= '0;
		steady = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: reset width of zero, no padding
		send_number(32'd0);
		send_number(32'd1);
		send_number(32'd9);
		send_number(32'd10);
		send_number(32'hFFFF_FFFF);
		send_number(32'hAAAA_AAAA);
		send_number(32'h5555_5555);
		// full width: zero padded as one digit
		write_width(MAX_WIDTH);
		send_number(32'd0);
		send_number(32'hFFFF_FFFF);
		send_number(32'd123);
		// width above sixteen saturates
		write_width(5'd31);
		send_number(32'd0);
		send_number(32'd12345);
		// width equal to and just above the digit count
		write_width(5'd10);
		send_number(32'hFFFF_FFFF);
		send_number(32'd999999999);
		send_number(32'd1000000000);
		// width at or below the digit count gives no spaces, except 100 at width five
		write_width(5'd1);
		send_number(32'd0);
		send_number(32'd55);
		write_width(5'd5);
		send_number(32'd12345);
		send_number(32'd2147483648);
		send_number(32'd100);

		// Random phases, each with its own width
		for (int phase = 0; phase < 8; phase++) begin
			write_width(random_width());
			steady = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < 10; i++) begin
				// occasional pause until all text is out
				if ($urandom_range(0, 7) == 0)
					drain();
				send_number(random_number());
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (ledger.errors == 0 && ledger.pending() == 0)
			$display("binary_to_decimal_ascii_tb: clean");
		else
			$display("binary_to_decimal_ascii_tb: errors");
		$finish;
	end

endmodule
